/* hw/rtl/crta_pkg.sv */
// Shared types and constants for the chunk range table appender.
// Holds the item structs, result codes and the controller/datapath command and status groups.
// Depends on nothing.
package crta_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned HELD_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_SIZE = 2'd2,
        STAT_OVERLAP  = 2'd3
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] packed_offset;
        logic [ADDR_W-1:0] packed_length;
        logic [ADDR_W-1:0] plain_offset;
        logic [ADDR_W-1:0] plain_length;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [HELD_W-1:0] entries_held;
    } out_item_t;

    // Stored entries keep the end of each range rather than its length.
    typedef struct packed {
        logic [ADDR_W-1:0] packed_start;
        logic [ADDR_W-1:0] packed_end;
        logic [ADDR_W-1:0] plain_start;
        logic [ADDR_W-1:0] plain_end;
    } entry_t;

    typedef struct packed {
        logic    capture;
        logic    walk_start;
        logic    walk_step;
        logic    emit;
        status_t emit_status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic bad_size;
        logic hit;
        logic walk_done;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/crta_ctrl.sv */
// Controller state machine of the chunk range table appender.
// Sequences check, table walk and result hand-off; uses crta_pkg.
// Talks to crta_datapath only through crta_pkg::cmd_t and crta_pkg::sts_t.
module crta_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  crta_pkg::sts_t  sts,
    output crta_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    crta_pkg::status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= crta_pkg::STAT_ACCEPTED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        status_next      = status_reg;
        cmd              = '0;
        cmd.emit_status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.full) begin
                    status_next = crta_pkg::STAT_FULL;
                    state_next  = S_EMIT;
                end else if (sts.bad_size) begin
                    status_next = crta_pkg::STAT_BAD_SIZE;
                    state_next  = S_EMIT;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.hit) begin
                    status_next = crta_pkg::STAT_OVERLAP;
                    state_next  = S_EMIT;
                end else if (sts.walk_done) begin
                    status_next = crta_pkg::STAT_ACCEPTED;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT: begin
                // The result waits here until the output register can take it.
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/crta_datapath.sv */
// Datapath of the chunk range table appender: input register, range checks,
// entry memory with walk counter, entry count, limit register and output register.
// Uses crta_pkg; driven by crta_ctrl.
module crta_datapath #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  crta_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output crta_pkg::out_item_t            m_data,
    input  logic                           cfg_we,
    input  logic [crta_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  crta_pkg::cmd_t                 cmd,
    output crta_pkg::sts_t                 sts
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CMP_W = (CNT_W > crta_pkg::LIMIT_W) ? CNT_W : crta_pkg::LIMIT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    crta_pkg::in_item_t          in_reg;
    logic [crta_pkg::ADDR_W-1:0] p_end_reg, q_end_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            rd_idx_reg;
    logic                        pend_reg;
    logic [crta_pkg::LIMIT_W-1:0] limit_reg;
    logic                        m_valid_reg;
    crta_pkg::out_item_t         m_data_reg;
    crta_pkg::entry_t            rd_data_reg;
    crta_pkg::entry_t            mem [MAX_ENTRIES];

    logic [crta_pkg::ADDR_W:0]   p_sum, q_sum;
    logic [CMP_W-1:0]            cnt_ext, lim_ext, cnt_next_ext;
    logic                        appending;
    crta_pkg::entry_t            new_entry;

    assign p_sum = {1'b0, in_reg.packed_offset} + {1'b0, in_reg.packed_length};
    assign q_sum = {1'b0, in_reg.plain_offset} + {1'b0, in_reg.plain_length};

    assign cnt_ext = CMP_W'(cnt_reg);
    assign lim_ext = CMP_W'(limit_reg);

    // A limit above the table depth acts as the depth.
    assign sts.full     = (cnt_ext >= lim_ext) || (cnt_reg == CNT_MAX);
    assign sts.bad_size = (in_reg.packed_length == '0) || (in_reg.plain_length == '0) ||
                          p_sum[crta_pkg::ADDR_W] || q_sum[crta_pkg::ADDR_W];

    // Both ranges are nonempty and do not wrap, so half-open overlap is two compares.
    assign sts.hit = pend_reg &&
                     (((in_reg.packed_offset < rd_data_reg.packed_end) &&
                       (rd_data_reg.packed_start < p_end_reg)) ||
                      ((in_reg.plain_offset < rd_data_reg.plain_end) &&
                       (rd_data_reg.plain_start < q_end_reg)));
    assign sts.walk_done = !pend_reg && (rd_idx_reg == cnt_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign appending = cmd.emit && (cmd.emit_status == crta_pkg::STAT_ACCEPTED);
    assign cnt_next  = appending ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cnt_next_ext = CMP_W'(cnt_next);

    assign new_entry.packed_start = in_reg.packed_offset;
    assign new_entry.packed_end   = p_end_reg;
    assign new_entry.plain_start  = in_reg.plain_offset;
    assign new_entry.plain_end    = q_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            limit_reg   <= crta_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.walk_start) begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
            end else if (cmd.walk_step) begin
                if (rd_idx_reg != cnt_reg) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    pend_reg   <= 1'b1;
                end else begin
                    pend_reg   <= 1'b0;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.walk_start) begin
            p_end_reg <= p_sum[crta_pkg::ADDR_W-1:0];
            q_end_reg <= q_sum[crta_pkg::ADDR_W-1:0];
        end
        if (cmd.emit) begin
            m_data_reg.status       <= cmd.emit_status;
            m_data_reg.entries_held <= cnt_next_ext[crta_pkg::HELD_W-1:0];
        end
    end

    // Entry memory: one write port for appends, one registered read port for the walk.
    always_ff @(posedge aclk) begin
        if (appending) begin
            mem[cnt_reg[IDX_W-1:0]] <= new_entry;
        end
        if (cmd.walk_step && (rd_idx_reg != cnt_reg)) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/chunk_range_table_appender.sv */
// Chunk range table appender. Items are taken one at a time: s_ready rises as the previous
// result is loaded into the output register. A full-table or size refusal goes from the check
// straight to the result; otherwise the result waits for the walk, which reads one stored
// entry per cycle; an overlap ends the walk early. A result held on m_ready delays the next
// one. Synchronous active-low reset empties the table, sets the limit to 64.
module chunk_range_table_appender #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  crta_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output crta_pkg::out_item_t           m_data,
    input  logic                          cfg_we,
    input  logic [crta_pkg::LIMIT_W-1:0]  cfg_wdata
);

    crta_pkg::cmd_t cmd;
    crta_pkg::sts_t sts;

    crta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crta_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* tb/tb_chunk_range_table_appender.sv */
// Self-checking testbench for the chunk range table appender.
// Predicts status and entry count for every descriptor and checks each result in order.
// Depends on crta_pkg and the chunk_range_table_appender top level.
module tb_chunk_range_table_appender;

    localparam int unsigned TABLE_DEPTH    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LIM_W          = crta_pkg::LIMIT_W;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum int {GEN_FRESH, GEN_OVERLAP, GEN_TOUCH, GEN_BAD_SIZE, GEN_NOISE} gen_kind_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    crta_pkg::in_item_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    crta_pkg::out_item_t  m_data;
    logic                 cfg_we;
    logic [LIM_W-1:0]     cfg_wdata;

    // Shadow copy of the descriptor table and the limit register.
    logic [crta_pkg::ADDR_W-1:0] held_packed_start [TABLE_DEPTH];
    logic [crta_pkg::ADDR_W-1:0] held_packed_len   [TABLE_DEPTH];
    logic [crta_pkg::ADDR_W-1:0] held_plain_start  [TABLE_DEPTH];
    logic [crta_pkg::ADDR_W-1:0] held_plain_len    [TABLE_DEPTH];
    int unsigned                 stored_count;
    logic [LIM_W-1:0]            entry_limit_shadow;

    crta_pkg::out_item_t pending_results [$];
    crta_pkg::out_item_t oldest_result;
    int unsigned mismatch_count;
    int unsigned result_index;
    int unsigned quiet_cycles;
    int unsigned burst_left;

    rx_mode_t    ready_mode;
    int unsigned ready_phase;
    logic [7:0]  ready_pattern;

    chunk_range_table_appender #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_range64(input int unsigned lo, input int unsigned hi);
        return 64'($urandom_range(lo, hi));
    endfunction

    function automatic logic range_wraps(input logic [63:0] start, input logic [63:0] len);
        logic [63:0] last;
        last = start + len;
        return last < start;
    endfunction

    // Half-open ranges; both have nonzero length and do not wrap.
    function automatic logic ranges_meet(input logic [63:0] a0, input logic [63:0] alen,
                                         input logic [63:0] b0, input logic [63:0] blen);
        logic [63:0] a_end;
        logic [63:0] b_end;
        a_end = a0 + alen;
        b_end = b0 + blen;
        if (a0 < b0) begin
            return a_end > b0;
        end
        if (a0 == b0) begin
            return 1'b1;
        end
        return b_end > a0;
    endfunction

    function automatic crta_pkg::out_item_t predict_append(input crta_pkg::in_item_t d);
        crta_pkg::out_item_t r;
        int unsigned         cap;
        cap = (32'(entry_limit_shadow) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(entry_limit_shadow);
        r.status = crta_pkg::STAT_ACCEPTED;
        if (stored_count >= cap) begin
            r.status = crta_pkg::STAT_FULL;
        end else if (d.packed_length == '0 || d.plain_length == '0 ||
                     range_wraps(d.packed_offset, d.packed_length) ||
                     range_wraps(d.plain_offset, d.plain_length)) begin
            r.status = crta_pkg::STAT_BAD_SIZE;
        end else begin
            for (int unsigned i = 0; i < stored_count; i++) begin
                if (ranges_meet(d.packed_offset, d.packed_length,
                                held_packed_start[i], held_packed_len[i]) ||
                    ranges_meet(d.plain_offset, d.plain_length,
                                held_plain_start[i], held_plain_len[i])) begin
                    r.status = crta_pkg::STAT_OVERLAP;
                    break;
                end
            end
            if (r.status == crta_pkg::STAT_ACCEPTED) begin
                held_packed_start[stored_count] = d.packed_offset;
                held_packed_len[stored_count]   = d.packed_length;
                held_plain_start[stored_count]  = d.plain_offset;
                held_plain_len[stored_count]    = d.plain_length;
                stored_count++;
            end
        end
        r.entries_held = stored_count[crta_pkg::HELD_W-1:0];
        return r;
    endfunction

    function automatic crta_pkg::in_item_t make_descriptor(input logic [63:0] po,
                                                           input logic [63:0] pl,
                                                           input logic [63:0] qo,
                                                           input logic [63:0] ql);
        crta_pkg::in_item_t d;
        d.packed_offset = po;
        d.packed_length = pl;
        d.plain_offset  = qo;
        d.plain_length  = ql;
        return d;
    endfunction

    // Fresh ranges sit in 16 MiB slots, clear of the directed entries.
    function automatic crta_pkg::in_item_t fresh_descriptor();
        crta_pkg::in_item_t d;
        logic [63:0]        base;
        base = rand_range64(1, 1 << 20);
        d.packed_offset = (base << 24) + rand_range64(0, 255);
        d.packed_length = rand_range64(1, 1 << 16);
        base = rand_range64(1, 1 << 20);
        d.plain_offset  = (base << 24) + rand_range64(0, 255);
        d.plain_length  = rand_range64(1, 1 << 16);
        return d;
    endfunction

    function automatic logic [63:0] point_within(input logic [63:0] start, input logic [63:0] len);
        return start + (rand64() % len);
    endfunction

    function automatic crta_pkg::in_item_t random_descriptor();
        crta_pkg::in_item_t d;
        gen_kind_t          kind;
        int unsigned        roll;
        int unsigned        k;
        d = fresh_descriptor();
        roll = $urandom_range(0, 99);
        if (roll < 30) kind = GEN_FRESH;
        else if (roll < 60) kind = GEN_OVERLAP;
        else if (roll < 70) kind = GEN_TOUCH;
        else if (roll < 85) kind = GEN_BAD_SIZE;
        else kind = GEN_NOISE;
        if (stored_count == 0 && (kind == GEN_OVERLAP || kind == GEN_TOUCH)) begin
            kind = GEN_FRESH;
        end
        k = (stored_count > 0) ? $urandom_range(0, stored_count - 1) : 0;
        case (kind)
            GEN_OVERLAP: begin
                roll = $urandom_range(0, 2);
                if (roll != 1) begin
                    d.packed_offset = point_within(held_packed_start[k], held_packed_len[k]);
                    d.packed_length = rand_range64(1, 4096);
                end
                if (roll != 0) begin
                    d.plain_offset = point_within(held_plain_start[k], held_plain_len[k]);
                    d.plain_length = rand_range64(1, 4096);
                end
            end
            GEN_TOUCH: begin
                d.packed_length = rand_range64(1, 4096);
                if ($urandom_range(0, 1) == 0 && held_packed_start[k] >= d.packed_length) begin
                    d.packed_offset = held_packed_start[k] - d.packed_length;
                end else begin
                    d.packed_offset = held_packed_start[k] + held_packed_len[k];
                end
            end
            GEN_BAD_SIZE: begin
                roll = $urandom_range(0, 4095);
                case ($urandom_range(0, 3))
                    0: d.packed_length = '0;
                    1: d.plain_length = '0;
                    2: begin
                        d.packed_offset = ~64'd0 - 64'(roll);
                        d.packed_length = 64'(roll) + 64'd1 + rand_range64(0, 4095);
                    end
                    default: begin
                        d.plain_offset = ~64'd0 - 64'(roll);
                        d.plain_length = 64'(roll) + 64'd1 + rand_range64(0, 4095);
                    end
                endcase
            end
            GEN_NOISE: begin
                d.packed_offset = rand64();
                d.packed_length = rand64() >> $urandom_range(0, 63);
                d.plain_offset  = rand64();
                d.plain_length  = rand64() >> $urandom_range(0, 63);
            end
            default: ;
        endcase
        return d;
    endfunction

    // Presents one item at a falling edge and returns at the falling edge after acceptance, or after a random gap.
    task automatic send_descriptor(input crta_pkg::in_item_t d);
        int unsigned gap;
        s_data  = d;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid    = 1'b0;
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 80) : $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_table_idle();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_entry_limit(input logic [LIM_W-1:0] value);
        wait_table_idle();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        entry_limit_shadow = value;
    endtask

    task automatic test_size_checks();
        send_descriptor(make_descriptor(64'h100, 64'h0, 64'h100, 64'h10));
        send_descriptor(make_descriptor(64'h100, 64'h10, 64'h100, 64'h0));
        send_descriptor(make_descriptor(~64'd0, 64'h1, 64'h100, 64'h1));
        // A range ending exactly at 2^64 counts as an overflow.
        send_descriptor(make_descriptor(64'h100, 64'h1, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10));
        send_descriptor(make_descriptor(~64'd0, ~64'd0, 64'h100, 64'h1));
        // Highest end that still fits is accepted.
        send_descriptor(make_descriptor(64'h0, 64'h10, 64'hFFFF_FFFF_FFFF_FFEF, 64'h10));
    endtask

    task automatic test_limit_extremes();
        write_entry_limit('0);
        send_descriptor(make_descriptor(64'h1000, 64'h100, 64'h1000, 64'h100));
        // The capacity check wins over the size check.
        send_descriptor(make_descriptor(64'h1000, 64'h0, 64'h1000, 64'h100));
        write_entry_limit('1);
        send_descriptor(make_descriptor(64'h1000, 64'h100, 64'h1000, 64'h100));
    endtask

    task automatic test_overlap_rules();
        send_descriptor(make_descriptor(64'h2000, 64'h100, 64'h2000, 64'h100));
        send_descriptor(make_descriptor(64'h1000, 64'h1, 64'h9000, 64'h1));
        send_descriptor(make_descriptor(64'h0F00, 64'h100, 64'h1100, 64'h10));
        send_descriptor(make_descriptor(64'h5000, 64'h10, 64'h10FF, 64'h1));
        send_descriptor(make_descriptor(64'h1F00, 64'h300, 64'hA000, 64'h1));
        send_descriptor(make_descriptor(64'h20FF, 64'h1000, 64'hB000, 64'h1));
        send_descriptor(make_descriptor(64'h0, ~64'd0, 64'h0, ~64'd0));
        send_descriptor(make_descriptor(64'h2100, 64'h8, 64'h3000, 64'h8));
    endtask

    task automatic test_limit_below_count();
        write_entry_limit(LIM_W'(stored_count - 3));
        send_descriptor(fresh_descriptor());
        write_entry_limit(LIM_W'(stored_count));
        send_descriptor(fresh_descriptor());
        write_entry_limit(LIM_W'(stored_count + 1));
        send_descriptor(fresh_descriptor());
        send_descriptor(fresh_descriptor());
    endtask

    task automatic test_random_traffic();
        logic [LIM_W-1:0] round_limit;
        int unsigned      round_items;
        for (int r = 0; r < 6; r++) begin
            round_items = 100;
            case (r)
                0: round_limit = LIM_W'(stored_count + $urandom_range(4, 10));
                1: begin
                    round_limit = LIM_W'($urandom_range(0, stored_count));
                    round_items = 40;
                end
                2: round_limit = LIM_W'(stored_count + $urandom_range(6, 16));
                3: begin
                    round_limit = LIM_W'($urandom_range(TABLE_DEPTH + 1, 127));
                    round_items = 120;
                end
                4: begin
                    round_limit = crta_pkg::LIMIT_RESET;
                    round_items = 140;
                end
                default: round_limit = LIM_W'($urandom_range(0, TABLE_DEPTH - 1));
            endcase
            write_entry_limit(round_limit);
            repeat (round_items) send_descriptor(random_descriptor());
        end
    endtask

    // Receiver stalls follow a mode (steady, random or a rotating pattern) that is redrawn at random times.
    initial begin
        m_ready     = 1'b0;
        ready_phase = 0;
        forever begin
            @(negedge aclk);
            if (ready_phase == 0) begin
                ready_phase   = $urandom_range(20, 120);
                ready_mode    = rx_mode_t'($urandom_range(0, 2));
                ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
            end
            ready_phase--;
            case (ready_mode)
                RX_STEADY: m_ready = 1'b1;
                RX_RANDOM: m_ready = ($urandom_range(0, 2) != 0);
                default: begin
                    m_ready       = ready_pattern[0];
                    ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_results.push_back(predict_append(s_data));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("result %0d arrived with nothing expected: status %0d held %0d",
                             result_index, m_data.status, m_data.entries_held);
                end
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_data.status !== oldest_result.status ||
                    m_data.entries_held !== oldest_result.entries_held) begin
                    if (mismatch_count < 10) begin
                        $display("result %0d: expected status %0d held %0d, got status %0d held %0d",
                                 result_index, oldest_result.status, oldest_result.entries_held,
                                 m_data.status, m_data.entries_held);
                    end
                    mismatch_count++;
                end
            end
            result_index++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        cfg_we             = 1'b0;
        cfg_wdata          = crta_pkg::LIMIT_RESET;
        entry_limit_shadow = crta_pkg::LIMIT_RESET;
        stored_count       = 0;
        mismatch_count     = 0;
        result_index       = 0;
        burst_left         = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_size_checks();
        test_limit_extremes();
        test_overlap_rules();
        test_limit_below_count();
        test_random_traffic();

        wait_table_idle();
        repeat (TABLE_DEPTH + 8) @(negedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/crta_pkg.sv
hw/rtl/crta_ctrl.sv
hw/rtl/crta_datapath.sv
hw/rtl/chunk_range_table_appender.sv
tb/tb_chunk_range_table_appender.sv
